// ===== design/keypad_code_lock_defines.svh =====
// Assertion macros shared by the keypad code lock modules.
// Each macro expects clk and arst_n to be visible in the module that uses it.
`ifndef KEYPAD_CODE_LOCK_DEFINES_SVH
`define KEYPAD_CODE_LOCK_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KCL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KCL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/kcl_pkg.sv =====
// Types, codes and constants for the keypad code lock.
// Used by every module of the block; depends on nothing else.
package kcl_pkg;

	// Widths fixed by the register map and the stream payloads.
	localparam int CODE_W       = 64;
	localparam int LEN_W        = 5;
	localparam int TIMEOUT_W    = 20;
	localparam int KEY_W        = 4;
	localparam int CFG_IDX_W    = 2;
	localparam int IN_TDATA_W   = 8;
	localparam int OUT_TDATA_W  = 16;

	// Defaults of the top-level parameters.
	localparam int DEF_MAX_CODE_KEYS = 16;
	localparam int DEF_TIMER_BITS    = 20;

	// Register values after reset.
	localparam logic [CODE_W-1:0]    RST_CODE_DIGITS   = '0;
	localparam logic [LEN_W-1:0]     RST_CODE_LENGTH   = 5'd4;
	localparam logic [TIMEOUT_W-1:0] RST_ENTRY_TIMEOUT = 20'd30000;
	localparam logic [TIMEOUT_W-1:0] RST_SLEEP_TIMEOUT = 20'd60000;

	// Command queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Key codes with a special meaning.
	localparam logic [KEY_W-1:0] KEY_STAR = 4'd14;
	localparam logic [KEY_W-1:0] KEY_HASH = 4'd15;

	// Request kinds on the input stream.
	typedef enum logic {
		OP_TICK = 1'b0,
		OP_KEY  = 1'b1
	} opcode_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CODE_DIGITS   = 2'd0,
		CFG_CODE_LENGTH   = 2'd1,
		CFG_ENTRY_TIMEOUT = 2'd2,
		CFG_SLEEP_TIMEOUT = 2'd3
	} cfg_index_t;

	// Classified command as it travels through the queue.
	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_SYMBOL = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_SUBMIT = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [KEY_W-1:0] key;
	} cmd_t;

	// Result codes.
	typedef enum logic [1:0] {
		LED_UNLOCKED = 2'd0,
		LED_ENTERING = 2'd1,
		LED_LOCKED   = 2'd2
	} led_t;

	typedef enum logic [1:0] {
		ALARM_NONE   = 2'd0,
		ALARM_ARM    = 2'd1,
		ALARM_DISARM = 2'd2
	} alarm_cmd_t;

	// Result word, laid out exactly as the output tdata (lowest field last here).
	typedef struct packed {
		logic [6:0] pad;
		logic       key_flash;
		logic       sleep_request;
		logic       entry_expired;
		logic       access_denied;
		logic [1:0] alarm_command;
		logic       locked;
		logic [1:0] led_state;
	} result_t;

	// Queue occupancy seen by the front.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

// ===== design/keypad_code_lock.sv =====
// Top level of the keypad code lock: front, command queue and back joined together.
// Depends on kcl_pkg, kcl_front, kcl_queue and kcl_back.
//
//  Channel   Direction  Signals                       Contents
//  s         in         s_tvalid s_tready s_tdata     key_code [3:0]; s_tuser opcode
//  m         out        m_tvalid m_tready m_tdata     led, locked, alarm, pulses
//  cfg       in         cfg_we cfg_index cfg_data     register writes, no read-back
//
// One request is taken per cycle while the queue has room; each gives one result,
// registered first into the command queue, then into the result register.
// The back decides each command combinationally, one per clock unless output stalls.
// Reset clears the entry, the timers and the lock, and restores the register defaults.
// A stalled output fills the two-entry queue; s_tready drops only when it is full.
module keypad_code_lock #(
	parameter int MAX_CODE_KEYS = kcl_pkg::DEF_MAX_CODE_KEYS,
	parameter int TIMER_BITS    = kcl_pkg::DEF_TIMER_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [kcl_pkg::IN_TDATA_W-1:0]  s_tdata,   // [3:0] key_code, [7:4] zero
	input  logic                            s_tuser,   // [0] opcode
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [1:0] led_state, [2] locked, [4:3] alarm_command, [5] access_denied,
	// [6] entry_expired, [7] sleep_request, [8] key_flash, [15:9] zero
	output logic [kcl_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                            cfg_we,
	input  logic [kcl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [kcl_pkg::CODE_W-1:0]      cfg_data
);
	import kcl_pkg::*;

	queue_stat_t qstat;
	logic        push;
	logic        pop;
	cmd_t        push_cmd;
	cmd_t        head_cmd;

	// Request classification.
	kcl_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.qstat    (qstat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// Decoupling queue.
	kcl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.qstat    (qstat)
	);

	// Command execution and result register.
	kcl_back #(
		.MAX_CODE_KEYS (MAX_CODE_KEYS),
		.TIMER_BITS    (TIMER_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.qstat     (qstat),
		.head_cmd  (head_cmd),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// ===== design/kcl_front.sv =====
// Front end of the keypad code lock: takes input requests and classifies them.
// Depends on kcl_pkg; feeds kcl_queue.
module kcl_front (
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [kcl_pkg::IN_TDATA_W-1:0] s_tdata,   // [3:0] key_code, [7:4] zero
	input  logic                           s_tuser,   // [0] opcode
	input  kcl_pkg::queue_stat_t           qstat,
	output logic                           push,
	output kcl_pkg::cmd_t                  push_cmd
);
	import kcl_pkg::*;

	logic [KEY_W-1:0] key;

	// A request is taken whenever the queue has room.
	assign s_tready = !qstat.full;
	assign push     = s_tvalid && s_tready;
	assign key      = s_tdata[KEY_W-1:0];

	// Sort each request into tick, symbol key, clear key or submit key.
	always_comb begin
		push_cmd.key = key;
		if (opcode_t'(s_tuser) == OP_TICK) begin
			push_cmd.kind = CMD_TICK;
		end else if (key == KEY_STAR) begin
			push_cmd.kind = CMD_CLEAR;
		end else if (key == KEY_HASH) begin
			push_cmd.kind = CMD_SUBMIT;
		end else begin
			push_cmd.kind = CMD_SYMBOL;
		end
	end

endmodule

// ===== design/kcl_queue.sv =====
// Short command queue between the front and the back of the keypad code lock.
// Depends on kcl_pkg and the shared assertion macros.
`include "keypad_code_lock_defines.svh"

module kcl_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  kcl_pkg::cmd_t        push_cmd,
	input  logic                 pop,
	output kcl_pkg::cmd_t        head_cmd,
	output kcl_pkg::queue_stat_t qstat
);
	import kcl_pkg::*;

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign qstat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign head_cmd    = slot_q[rd_ptr_q];

	// Entry storage; the payload needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// The fill level stays within the depth and tracks pushes and pops.
	`KCL_ASSERT_NOW(a_q_bounded, 1'b1, count_q <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
	`KCL_ASSERT_NOW(a_q_pop_nonempty, pop, count_q != '0, "pop from an empty queue")
	`KCL_ASSERT_NEXT(a_q_grows, push && !pop, count_q == QCNT_W'($past(count_q) + 1'b1), "fill level lost a push")

endmodule

// ===== design/kcl_back.sv =====
// Back end of the keypad code lock: configuration, entry state, timers and result register.
// Depends on kcl_pkg and the shared assertion macros; fed by kcl_queue.
`include "keypad_code_lock_defines.svh"

module kcl_back #(
	parameter int MAX_CODE_KEYS = kcl_pkg::DEF_MAX_CODE_KEYS,
	parameter int TIMER_BITS    = kcl_pkg::DEF_TIMER_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [kcl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [kcl_pkg::CODE_W-1:0]      cfg_data,
	input  kcl_pkg::queue_stat_t            qstat,
	input  kcl_pkg::cmd_t                   head_cmd,
	output logic                            pop,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [kcl_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import kcl_pkg::*;

	localparam int CNT_W = $clog2(MAX_CODE_KEYS + 1);
	localparam int CMP_W = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;

	// Configuration registers.
	logic [CODE_W-1:0]    code_digits_q;
	logic [LEN_W-1:0]     code_length_q;
	logic [TIMEOUT_W-1:0] entry_timeout_q;
	logic [TIMEOUT_W-1:0] sleep_timeout_q;

	// Entry and timer state.
	logic [CNT_W-1:0]      entry_count_q;
	logic                  entry_overflow_q;
	logic                  entry_matches_q;
	logic                  lock_flag_q;
	logic [TIMER_BITS-1:0] idle_ticks_q;
	logic [TIMER_BITS-1:0] entry_ticks_q;

	// Result register.
	logic    m_tvalid_q;
	result_t result_q;

	// Next values.
	logic [CNT_W-1:0]      count_nx;
	logic                  overflow_nx;
	logic                  matches_nx;
	logic                  lock_nx;
	logic [TIMER_BITS-1:0] idle_nx;
	logic [TIMER_BITS-1:0] etick_nx;
	result_t               result_nx;

	logic [TIMER_BITS-1:0] idle_inc;
	logic [TIMER_BITS-1:0] etick_inc;
	logic [LEN_W-1:0]      count_ext;
	logic [CODE_W-1:0]     code_shift;
	logic [KEY_W-1:0]      want_key;

	// Take the next command when the result register is free or being emptied.
	assign pop      = !qstat.empty && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = result_q;

	// Saturating timer increments.
	assign idle_inc  = (&idle_ticks_q) ? idle_ticks_q : idle_ticks_q + 1'b1;
	assign etick_inc = (&entry_ticks_q) ? entry_ticks_q : entry_ticks_q + 1'b1;

	// Stored key expected at the current entry position.
	assign count_ext  = LEN_W'(entry_count_q);
	assign code_shift = code_digits_q >> {count_ext[KEY_W-1:0], 2'b00};
	assign want_key   = code_shift[KEY_W-1:0];

	// Effect of one command on the entry, the lock and the timers.
	always_comb begin
		count_nx    = entry_count_q;
		overflow_nx = entry_overflow_q;
		matches_nx  = entry_matches_q;
		lock_nx     = lock_flag_q;
		idle_nx     = idle_ticks_q;
		etick_nx    = entry_ticks_q;
		result_nx   = '0;

		case (head_cmd.kind)
			CMD_TICK: begin
				if (CMP_W'(idle_inc) > CMP_W'(sleep_timeout_q)) begin
					result_nx.sleep_request = 1'b1;
					count_nx    = '0;
					overflow_nx = 1'b0;
					matches_nx  = 1'b1;
					idle_nx     = '0;
					etick_nx    = '0;
				end else begin
					idle_nx = idle_inc;
					if (entry_count_q != '0) begin
						if (CMP_W'(etick_inc) > CMP_W'(entry_timeout_q)) begin
							result_nx.entry_expired = 1'b1;
							count_nx    = '0;
							overflow_nx = 1'b0;
							matches_nx  = 1'b1;
							etick_nx    = '0;
						end else begin
							etick_nx = etick_inc;
						end
					end
				end
			end
			CMD_CLEAR: begin
				result_nx.key_flash = 1'b1;
				idle_nx     = '0;
				etick_nx    = '0;
				count_nx    = '0;
				overflow_nx = 1'b0;
				matches_nx  = 1'b1;
			end
			CMD_SUBMIT: begin
				result_nx.key_flash = 1'b1;
				idle_nx  = '0;
				etick_nx = '0;
				if (!entry_overflow_q && entry_matches_q && count_ext == code_length_q) begin
					lock_nx = !lock_flag_q;
					result_nx.alarm_command = lock_nx ? ALARM_ARM : ALARM_DISARM;
				end else begin
					result_nx.access_denied = 1'b1;
				end
				count_nx    = '0;
				overflow_nx = 1'b0;
				matches_nx  = 1'b1;
			end
			CMD_SYMBOL: begin
				result_nx.key_flash = 1'b1;
				idle_nx  = '0;
				etick_nx = '0;
				if (entry_count_q < CNT_W'(MAX_CODE_KEYS)) begin
					if (count_ext >= code_length_q || want_key != head_cmd.key) begin
						matches_nx = 1'b0;
					end
					count_nx = entry_count_q + 1'b1;
				end else begin
					overflow_nx = 1'b1;
					matches_nx  = 1'b0;
				end
			end
			default: begin
				result_nx = '0;
			end
		endcase

		result_nx.locked = lock_nx;
		if (count_nx != '0) begin
			result_nx.led_state = LED_ENTERING;
		end else if (lock_nx) begin
			result_nx.led_state = LED_LOCKED;
		end else begin
			result_nx.led_state = LED_UNLOCKED;
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_digits_q   <= RST_CODE_DIGITS;
			code_length_q   <= RST_CODE_LENGTH;
			entry_timeout_q <= RST_ENTRY_TIMEOUT;
			sleep_timeout_q <= RST_SLEEP_TIMEOUT;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_CODE_DIGITS:   code_digits_q   <= cfg_data;
				CFG_CODE_LENGTH:   code_length_q   <= cfg_data[LEN_W-1:0];
				CFG_ENTRY_TIMEOUT: entry_timeout_q <= cfg_data[TIMEOUT_W-1:0];
				CFG_SLEEP_TIMEOUT: sleep_timeout_q <= cfg_data[TIMEOUT_W-1:0];
				default: ;
			endcase
		end
	end

	// Entry state and timers advance on every command taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q    <= '0;
			entry_overflow_q <= 1'b0;
			entry_matches_q  <= 1'b1;
			lock_flag_q      <= 1'b0;
			idle_ticks_q     <= '0;
			entry_ticks_q    <= '0;
		end else if (pop) begin
			entry_count_q    <= count_nx;
			entry_overflow_q <= overflow_nx;
			entry_matches_q  <= matches_nx;
			lock_flag_q      <= lock_nx;
			idle_ticks_q     <= idle_nx;
			entry_ticks_q    <= etick_nx;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (pop) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			result_q <= result_nx;
		end
	end

	// A tick never flashes, denies or commands the alarms; a submit always empties the entry
	// and gives exactly one verdict; an overflowed entry never counts as matching.
	`KCL_ASSERT_NEXT(a_tick_quiet, pop && head_cmd.kind == CMD_TICK, !result_q.key_flash && !result_q.access_denied && result_q.alarm_command == ALARM_NONE, "tick produced a key event")
	`KCL_ASSERT_NEXT(a_submit_verdict, pop && head_cmd.kind == CMD_SUBMIT, entry_count_q == '0 && (result_q.access_denied != (result_q.alarm_command != ALARM_NONE)), "submit without a single verdict")
	`KCL_ASSERT_NOW(a_overflow_nomatch, entry_overflow_q, !entry_matches_q, "overflowed entry still matching")

endmodule

// ===== tb/tb_keypad_code_lock.sv =====
// Self-checking testbench for keypad_code_lock: a table of directed key and tick requests,
// then randomised entry sequences under several register settings and handshake pressures.
// Depends on kcl_pkg and keypad_code_lock; results are predicted by a model held in this file.
`timescale 1ns / 100ps

module tb_keypad_code_lock;
	import kcl_pkg::*;

	localparam int MAX_KEYS      = DEF_MAX_CODE_KEYS;
	localparam int TIMER_BITS    = DEF_TIMER_BITS;
	localparam int RESET_CYCLES  = 9;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES  = 8;
	localparam int HOLD_CYCLES   = 400;
	localparam int PHASE_ITEMS   = 72;
	localparam int NUM_PHASES    = 8;
	localparam int LIMIT_CYCLES  = 400000;
	localparam int REPORT_MAX    = 10;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_MAX = '1;

	// One complete register setting.
	typedef struct packed {
		logic [CODE_W-1:0]    code;
		logic [LEN_W-1:0]     len;
		logic [TIMEOUT_W-1:0] etmo;
		logic [TIMEOUT_W-1:0] stmo;
	} lock_cfg_t;

	typedef enum logic {ROW_REQ, ROW_SETUP} row_kind_t;

	// A row of the directed table: a request, optionally with a typed-in result, or a setting.
	typedef struct {
		row_kind_t        kind;
		opcode_t          op;
		logic [KEY_W-1:0] key;
		bit               typed;
		result_t          want;
		lock_cfg_t        setup;
	} row_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                   s_tuser   = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CODE_W-1:0]      cfg_data  = '0;

	// Handshake pressure, set by the stimulus process and the long-stall process.
	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	bit hold_arm     = 1'b0;
	logic rx_hold    = 1'b0;

	int items_sent = 0;
	int mismatches = 0;
	int results_seen = 0;
	result_t pending_results[$];

	// Predicted state of the lock and its current setting.
	logic [LEN_W-1:0]      entry_count    = '0;
	logic                  entry_overflow = 1'b0;
	logic                  entry_matches  = 1'b1;
	logic                  lock_flag      = 1'b0;
	logic [TIMER_BITS-1:0] idle_ticks     = '0;
	logic [TIMER_BITS-1:0] entry_ticks    = '0;
	lock_cfg_t cur_cfg = '{RST_CODE_DIGITS, RST_CODE_LENGTH, RST_ENTRY_TIMEOUT, RST_SLEEP_TIMEOUT};

	keypad_code_lock dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// Lock state prediction.
	function automatic void clear_entry();
		entry_count    = '0;
		entry_overflow = 1'b0;
		entry_matches  = 1'b1;
	endfunction

	function automatic logic [TIMER_BITS-1:0] bump(logic [TIMER_BITS-1:0] t);
		return (t == '1) ? t : t + 1'b1;
	endfunction

	function automatic result_t lock_step(opcode_t op, logic [KEY_W-1:0] key);
		result_t r;
		logic [KEY_W-1:0] want_key;
		r = '0;
		if (op == OP_KEY) begin
			idle_ticks  = '0;
			entry_ticks = '0;
			r.key_flash = 1'b1;
			if (key == KEY_STAR) begin
				clear_entry();
			end else if (key == KEY_HASH) begin
				if (!entry_overflow && entry_matches && entry_count == cur_cfg.len) begin
					lock_flag = !lock_flag;
					r.alarm_command = lock_flag ? ALARM_ARM : ALARM_DISARM;
				end else begin
					r.access_denied = 1'b1;
				end
				clear_entry();
			end else if (entry_count < MAX_KEYS) begin
				want_key = KEY_W'(cur_cfg.code >> (4 * entry_count[3:0]));
				if (entry_count >= cur_cfg.len || want_key != key)
					entry_matches = 1'b0;
				entry_count = entry_count + 1'b1;
			end else begin
				entry_overflow = 1'b1;
				entry_matches  = 1'b0;
			end
		end else begin
			idle_ticks = bump(idle_ticks);
			if (idle_ticks > cur_cfg.stmo) begin
				r.sleep_request = 1'b1;
				clear_entry();
				idle_ticks  = '0;
				entry_ticks = '0;
			end else if (entry_count != 0) begin
				entry_ticks = bump(entry_ticks);
				if (entry_ticks > cur_cfg.etmo) begin
					r.entry_expired = 1'b1;
					clear_entry();
					entry_ticks = '0;
				end
			end
		end
		r.led_state = (entry_count != 0) ? LED_ENTERING : (lock_flag ? LED_LOCKED : LED_UNLOCKED);
		r.locked    = lock_flag;
		return r;
	endfunction

	// Table construction.
	function automatic result_t outcome(led_t led, logic lk, alarm_cmd_t al, logic den,
			logic expd, logic slp, logic fl);
		result_t r;
		r = '0;
		r.led_state     = led;
		r.locked        = lk;
		r.alarm_command = al;
		r.access_denied = den;
		r.entry_expired = expd;
		r.sleep_request = slp;
		r.key_flash     = fl;
		return r;
	endfunction

	function automatic row_t req_row(opcode_t op, logic [KEY_W-1:0] key);
		row_t row;
		row = '{ROW_REQ, op, key, 1'b0, '0, '0};
		return row;
	endfunction

	function automatic row_t checked_row(opcode_t op, logic [KEY_W-1:0] key, result_t want);
		row_t row;
		row = '{ROW_REQ, op, key, 1'b1, want, '0};
		return row;
	endfunction

	function automatic row_t setup_row(logic [CODE_W-1:0] code, logic [LEN_W-1:0] len,
			logic [TIMEOUT_W-1:0] etmo, logic [TIMEOUT_W-1:0] stmo);
		row_t row;
		row = '{ROW_SETUP, OP_TICK, '0, 1'b0, '0, '{code, len, etmo, stmo}};
		return row;
	endfunction

	function automatic string describe(result_t r);
		return $sformatf("led=%0d locked=%0b alarm=%0d denied=%0b expired=%0b sleep=%0b flash=%0b pad=%0h",
			r.led_state, r.locked, r.alarm_command, r.access_denied, r.entry_expired,
			r.sleep_request, r.key_flash, r.pad);
	endfunction

	// Offers one request, waits for its handshake and records the result it must give.
	task automatic send_req(opcode_t op, logic [KEY_W-1:0] key, bit typed = 1'b0,
			result_t want = '0);
		result_t predicted;
		if ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_TDATA_W-KEY_W){1'b0}}, key};
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		predicted = lock_step(op, key);
		pending_results.push_back(typed ? want : predicted);
		items_sent++;
	endtask

	// Ticks carry random key bits, which the block must ignore.
	task automatic send_ticks(int count);
		for (int i = 0; i < count; i++)
			send_req(OP_TICK, KEY_W'($urandom_range(15)));
	endtask

	// Stops offering requests until every outstanding result has been taken.
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes all four registers in turn; the block must be idle.
	task automatic program_lock(lock_cfg_t c);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_CODE_DIGITS;
		cfg_data  <= c.code;
		@(posedge clk);
		cfg_index <= CFG_CODE_LENGTH;
		cfg_data  <= CODE_W'(c.len);
		@(posedge clk);
		cfg_index <= CFG_ENTRY_TIMEOUT;
		cfg_data  <= CODE_W'(c.etmo);
		@(posedge clk);
		cfg_index <= CFG_SLEEP_TIMEOUT;
		cfg_data  <= CODE_W'(c.stmo);
		@(posedge clk);
		cfg_we  <= 1'b0;
		cur_cfg = c;
	endtask

	// One user interaction: mostly the stored code with noise, sometimes a broken attempt.
	task automatic send_sequence();
		int form, n, bad_pos, run, span;
		logic [KEY_W-1:0] k;
		form = $urandom_range(99);
		n = (cur_cfg.len > MAX_KEYS) ? MAX_KEYS : int'(cur_cfg.len);
		if (form < 60) begin
			// The stored code, correct or with one wrong or extra key, then submit.
			bad_pos = (form < 45) ? -1 : $urandom_range(n);
			for (int i = 0; i < n; i++) begin
				k = KEY_W'(cur_cfg.code >> (4 * i));
				if (i == bad_pos)
					k = KEY_W'($urandom_range(13));
				if ($urandom_range(99) < 15)
					send_ticks($urandom_range(1, 3));
				send_req(OP_KEY, k);
			end
			if (bad_pos == n)
				send_req(OP_KEY, KEY_W'($urandom_range(13)));
			send_req(OP_KEY, KEY_HASH);
		end else if (form < 68) begin
			// An entry longer than the keypad buffer, starting with the stored code.
			for (int i = 0; i < MAX_KEYS + $urandom_range(1, 3); i++) begin
				k = (i < MAX_KEYS) ? KEY_W'(cur_cfg.code >> (4 * i)) : KEY_W'($urandom_range(13));
				send_req(OP_KEY, k);
			end
			send_req(OP_KEY, KEY_HASH);
		end else if (form < 78) begin
			// A few random keys, then cleared or submitted.
			for (int i = 0; i < $urandom_range(5); i++)
				send_req(OP_KEY, KEY_W'($urandom_range(13)));
			send_req(OP_KEY, $urandom_range(1) ? KEY_STAR : KEY_HASH);
		end else if (form < 92) begin
			// A partial entry left to time out, or the keypad left to fall asleep.
			for (int i = 0; i < $urandom_range(3); i++)
				send_req(OP_KEY, KEY_W'(cur_cfg.code >> (4 * i)));
			if ($urandom_range(3) == 0)
				span = (cur_cfg.stmo > 60) ? 60 : int'(cur_cfg.stmo);
			else
				span = (cur_cfg.etmo > 40) ? 40 : int'(cur_cfg.etmo);
			run = $urandom_range(1, span + 2);
			send_ticks(run);
		end else begin
			// Unstructured noise over the whole input space.
			for (int i = 0; i < $urandom_range(1, 4); i++)
				send_req($urandom_range(1) ? OP_KEY : OP_TICK, KEY_W'($urandom_range(15)));
		end
	endtask

	// Compares one result with the oldest prediction.
	task automatic check_result(result_t got);
		result_t want;
		bit bad;
		results_seen++;
		if (pending_results.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("result %0d arrived with nothing outstanding: %s",
					results_seen, describe(got));
			return;
		end
		want = pending_results.pop_front();
		bad = (got.led_state !== want.led_state) || (got.locked !== want.locked)
			|| (got.alarm_command !== want.alarm_command)
			|| (got.access_denied !== want.access_denied)
			|| (got.entry_expired !== want.entry_expired)
			|| (got.sleep_request !== want.sleep_request)
			|| (got.key_flash !== want.key_flash) || (got.pad !== want.pad);
		if (bad) begin
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("result %0d mismatch: expected %s, got %s",
					results_seen, describe(want), describe(got));
		end
	endtask

	// Result sink: check on each handshake, then choose the next ready level.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_result(result_t'(m_tdata));
		m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
	end

	// Long stall of the result side, so the command queue fills and back-pressures requests.
	initial begin
		wait (hold_arm);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// Run limit.
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("CHECKS FAILED");
		$finish;
	end

	// Stimulus.
	initial begin
		row_t plan[$];
		lock_cfg_t c;
		int phase_end;

		plan = '{
			// Straight after reset: code 0000, four keys, long timeouts.
			checked_row(OP_TICK, 4'd0, outcome(LED_UNLOCKED, 0, ALARM_NONE, 0, 0, 0, 0)),
			checked_row(OP_TICK, 4'd15, outcome(LED_UNLOCKED, 0, ALARM_NONE, 0, 0, 0, 0)),
			checked_row(OP_KEY, 4'd0, outcome(LED_ENTERING, 0, ALARM_NONE, 0, 0, 0, 1)),
			req_row(OP_KEY, 4'd9),
			req_row(OP_KEY, 4'd10),
			req_row(OP_KEY, 4'd13),
			checked_row(OP_KEY, KEY_STAR, outcome(LED_UNLOCKED, 0, ALARM_NONE, 0, 0, 0, 1)),
			checked_row(OP_KEY, KEY_HASH, outcome(LED_UNLOCKED, 0, ALARM_NONE, 1, 0, 0, 1)),
			req_row(OP_KEY, 4'd0),
			req_row(OP_KEY, 4'd0),
			req_row(OP_KEY, 4'd0),
			req_row(OP_KEY, 4'd0),
			checked_row(OP_KEY, KEY_HASH, outcome(LED_LOCKED, 1, ALARM_ARM, 0, 0, 0, 1)),
			// Empty code: submitting an empty entry matches and unlocks.
			setup_row('0, 5'd0, RST_ENTRY_TIMEOUT, RST_SLEEP_TIMEOUT),
			checked_row(OP_KEY, KEY_HASH, outcome(LED_UNLOCKED, 0, ALARM_DISARM, 0, 0, 0, 1)),
			req_row(OP_KEY, 4'd7),
			checked_row(OP_KEY, KEY_HASH, outcome(LED_UNLOCKED, 0, ALARM_NONE, 1, 0, 0, 1)),
			// Zero entry timeout: the first tick with an open entry expires it.
			setup_row('0, 5'd0, '0, RST_SLEEP_TIMEOUT),
			req_row(OP_KEY, 4'd3),
			checked_row(OP_TICK, 4'd0, outcome(LED_UNLOCKED, 0, ALARM_NONE, 0, 1, 0, 0)),
			// Zero sleep timeout: sleep wins over the entry expiry on the same tick.
			setup_row('0, 5'd0, '0, '0),
			req_row(OP_KEY, 4'd11),
			checked_row(OP_TICK, 4'd0, outcome(LED_UNLOCKED, 0, ALARM_NONE, 0, 0, 1, 0)),
			// Code length beyond the buffer can never match; timeouts at their maximum.
			setup_row('1, 5'd31, TIMEOUT_MAX, TIMEOUT_MAX),
			checked_row(OP_KEY, KEY_HASH, outcome(LED_UNLOCKED, 0, ALARM_NONE, 1, 0, 0, 1)),
			checked_row(OP_KEY, KEY_STAR, outcome(LED_UNLOCKED, 0, ALARM_NONE, 0, 0, 0, 1)),
			req_row(OP_TICK, 4'd5)
		};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_SETUP) begin
				settle();
				program_lock(plan[i].setup);
			end else begin
				send_req(plan[i].op, plan[i].key, plan[i].typed, plan[i].want);
			end
		end

		// Random phases, each under its own setting and handshake pressure.
		for (int p = 0; p < NUM_PHASES; p++) begin
			for (int d = 0; d < MAX_KEYS; d++)
				c.code[4*d +: 4] = KEY_W'($urandom_range(13));
			c.len  = LEN_W'($urandom_range(1, 8));
			c.etmo = TIMEOUT_W'($urandom_range(2, 10));
			c.stmo = TIMEOUT_W'($urandom_range(15, 40));
			tx_idle_pct  = 0;
			rx_stall_pct = 0;
			case (p)
				0: begin
					c.len  = 5'd4;
					c.etmo = 20'd6;
					c.stmo = 20'd25;
				end
				1: tx_idle_pct = 82;
				2: rx_stall_pct = 82;
				3: begin
					tx_idle_pct  = 25;
					rx_stall_pct = 25;
				end
				4: begin
					c.code = '0;
					c.len  = LEN_W'(MAX_KEYS);
					c.etmo = TIMEOUT_MAX;
					c.stmo = TIMEOUT_MAX;
				end
				5: begin
					c.len        = '0;
					c.etmo       = '0;
					c.stmo       = TIMEOUT_MAX;
					tx_idle_pct  = 25;
					rx_stall_pct = 25;
				end
				6: begin
					c.len        = LEN_W'($urandom_range(MAX_KEYS + 1, 31));
					c.etmo       = TIMEOUT_W'($urandom_range(1, 8));
					c.stmo       = TIMEOUT_W'($urandom_range(1, 3));
					rx_stall_pct = 82;
				end
				default: begin
					c.len       = LEN_W'($urandom_range(1, MAX_KEYS));
					c.etmo      = TIMEOUT_W'($urandom_range(12));
					c.stmo      = TIMEOUT_W'($urandom_range(10, 50));
					tx_idle_pct = 82;
				end
			endcase
			settle();
			program_lock(c);
			if (p == 0)
				hold_arm = 1'b1;
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				if ($urandom_range(99) < 4)
					settle();
				send_sequence();
			end
		end

		// Let the last results drain.
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
